// ----- design/rgcq_pkg.sv -----
// Shared constants, types and helpers for the region growing colour quantizer.
`timescale 1ns / 1ps
package rgcq_pkg;

    localparam int MAX_ROWS = 480;
    localparam int MAX_COLS = 640;
    localparam int MAX_PIX  = MAX_ROWS * MAX_COLS;

    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int COL_W   = $clog2(MAX_COLS + 1);
    localparam int ADDR_W  = $clog2(MAX_PIX + 1);
    localparam int MEM_D   = MAX_PIX + 1;
    localparam int LABEL_W = 19;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int SUM_W   = CH_W + ADDR_W;
    localparam int QENT_W  = ROW_W + COL_W;

    localparam int THR_W      = 7;
    localparam int RCFG_W     = 9;
    localparam int CCFG_W     = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS      = 2'd2;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 7'd20;
    localparam logic [RCFG_W-1:0] ROWS_RESET      = 9'd480;
    localparam logic [CCFG_W-1:0] COLS_RESET      = 10'd640;

    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    typedef logic [2:0][SUM_W-1:0] sums_t;
    typedef logic [2:0][CH_W-1:0]  chans_t;

    typedef struct packed {
        logic [1:0] dr;
        logic [1:0] dc;
    } nbr_ofs_t;

    function automatic nbr_ofs_t nbr_ofs(input logic [2:0] dir);
        nbr_ofs_t o;
        case (dir)
            3'd0:    o = '{dr: OFS_MINUS, dc: OFS_MINUS};
            3'd1:    o = '{dr: OFS_MINUS, dc: OFS_ZERO};
            3'd2:    o = '{dr: OFS_MINUS, dc: OFS_PLUS};
            3'd3:    o = '{dr: OFS_ZERO,  dc: OFS_MINUS};
            3'd4:    o = '{dr: OFS_ZERO,  dc: OFS_PLUS};
            3'd5:    o = '{dr: OFS_PLUS,  dc: OFS_MINUS};
            3'd6:    o = '{dr: OFS_PLUS,  dc: OFS_ZERO};
            default: o = '{dr: OFS_PLUS,  dc: OFS_PLUS};
        endcase
        return o;
    endfunction

endpackage

// ----- design/rgcq_ram.sv -----
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module rgcq_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = $clog2(D)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [W-1:0]  wdata,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- design/rgcq_div.sv -----
// Three-lane restoring divider producing 8-bit region means.
`timescale 1ns / 1ps
module rgcq_div
    import rgcq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sums_t             sums,
    input  logic [ADDR_W-1:0] size,
    output logic              done,
    output chans_t            quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  bit_reg, bit_next;
    sums_t       rem_reg, rem_next;
    chans_t      q_reg, q_next;
    logic [ADDR_W-1:0] dsr_reg, dsr_next;
    logic [SUM_W-1:0]  shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        shifted   = SUM_W'(dsr_reg) << bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            bit_next  = 3'd7;
            rem_next  = sums;
            q_next    = '0;
            dsr_next  = size;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (rem_reg[k] >= shifted)
                begin
                    rem_next[k]       = rem_reg[k] - shifted;
                    q_next[k][bit_reg] = 1'b1;
                end
            end
            if (bit_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                bit_next = bit_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- design/region_grow_colour_quantizer_top.sv -----
// Top level: frame load, region growing sequencer and result readout.
//
//  channel   signals                               handshake
//  command   start, busy, kind, ch0, ch1, ch2      start && !busy
//  result    out_valid, out_ch0..2, region_label,  one-cycle strobe
//            last_pixel
//  config    wr_en, wr_index, wr_data              wr_en
//
// Loads stream back to back. A read passes through the label memory, then the
// mean memory, then the output register.
// The last load of a frame starts a label clearing pass over rows*cols pixels,
// then a scan of every pixel, growing a region from each unlabelled one through
// its queued pixels and their eight neighbours, and the mean divider per region.
// busy stays high for all of it. Results cannot be stalled.
`timescale 1ns / 1ps
module region_grow_colour_quantizer_top
    import rgcq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [CH_W-1:0]       ch0,
    input  logic [CH_W-1:0]       ch1,
    input  logic [CH_W-1:0]       ch2,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output logic                  out_valid,
    output logic [CH_W-1:0]       out_ch0,
    output logic [CH_W-1:0]       out_ch1,
    output logic [CH_W-1:0]       out_ch2,
    output logic [LABEL_W-1:0]    region_label,
    output logic                  last_pixel
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RLAB  = 4'd1;
    localparam logic [3:0] ST_RMEAN = 4'd2;
    localparam logic [3:0] ST_CLR   = 4'd3;
    localparam logic [3:0] ST_SRD   = 4'd4;
    localparam logic [3:0] ST_SCHK  = 4'd5;
    localparam logic [3:0] ST_GQRD  = 4'd6;
    localparam logic [3:0] ST_GQWT  = 4'd7;
    localparam logic [3:0] ST_NADR  = 4'd8;
    localparam logic [3:0] ST_NRD   = 4'd9;
    localparam logic [3:0] ST_NDAT  = 4'd10;
    localparam logic [3:0] ST_NTST  = 4'd11;
    localparam logic [3:0] ST_DIV   = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [THR_W-1:0]  thr_reg;
    logic [RCFG_W-1:0] rows_reg;
    logic [CCFG_W-1:0] cols_reg;

    logic [ADDR_W-1:0] load_ptr_reg, load_ptr_next;
    logic [ADDR_W-1:0] read_ptr_reg, read_ptr_next;
    logic              ready_reg, ready_next;
    logic [ADDR_W-1:0] fn_reg, fn_next;
    logic [ROW_W-1:0]  frows_reg, frows_next;
    logic [COL_W-1:0]  fcols_reg, fcols_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ROW_W-1:0]  sr_reg, sr_next;
    logic [COL_W-1:0]  sc_reg, sc_next;
    logic [LABEL_W-1:0] rc_reg, rc_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [2:0]        dir_reg, dir_next;
    logic [ADDR_W-1:0] size_reg, size_next;
    sums_t             sums_reg, sums_next;
    logic [ROW_W-1:0]  cr_reg, cr_next;
    logic [COL_W-1:0]  cc_reg, cc_next;
    logic [ROW_W-1:0]  nr_reg, nr_next;
    logic [COL_W-1:0]  nc_reg, nc_next;
    logic [ADDR_W-1:0] nidx_reg, nidx_next;
    sums_t             pc_reg, pc_next;
    logic [SUM_W-1:0]  lim_reg, lim_next;
    logic [PIX_W-1:0]  npix_reg, npix_next;
    logic [LABEL_W-1:0] lab_reg, lab_next;
    logic              ov_reg, ov_next;
    logic              olast_reg, olast_next;
    logic [PIX_W-1:0]  omean_reg, omean_next;
    logic [LABEL_W-1:0] olab_reg, olab_next;

    logic               lab_we, pix_we, q_we, mean_we;
    logic [ADDR_W-1:0]  lab_addr, pix_addr, q_addr, mean_addr;
    logic [LABEL_W-1:0] lab_wdata, lab_rdata;
    logic [PIX_W-1:0]   pix_wdata, pix_rdata, mean_wdata, mean_rdata;
    logic [QENT_W-1:0]  q_wdata, q_rdata;

    logic              div_start, div_done;
    chans_t            div_quot;

    logic [ROW_W-1:0]  sat_r;
    logic [COL_W-1:0]  sat_c;
    logic [ADDR_W-1:0] frame_n;
    logic              accept;
    nbr_ofs_t          ofs;
    logic              inb;
    logic [ROW_W-1:0]  nr_c;
    logic [COL_W-1:0]  nc_c;
    logic              joins;
    logic [SUM_W-1:0]  delta;
    logic              adv_scan, adv_dir;

    assign sat_r = (rows_reg == '0) ? ROW_W'(1) :
                   (32'(rows_reg) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(rows_reg);
    assign sat_c = (cols_reg == '0) ? COL_W'(1) :
                   (32'(cols_reg) > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(cols_reg);
    assign frame_n = ADDR_W'(ADDR_W'(sat_r) * ADDR_W'(sat_c));
    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RESET;
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_THRESHOLD: thr_reg  <= THR_W'(wr_data);
                REG_ROWS:      rows_reg <= RCFG_W'(wr_data);
                REG_COLS:      cols_reg <= CCFG_W'(wr_data);
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        ofs  = nbr_ofs(dir_reg);
        inb  = 1'b1;
        nr_c = cr_reg;
        nc_c = cc_reg;
        if (ofs.dr == OFS_MINUS)
        begin
            inb  = inb && (cr_reg != '0);
            nr_c = cr_reg - ROW_W'(1);
        end
        else if (ofs.dr == OFS_PLUS)
        begin
            inb  = inb && ((ROW_W + 1)'(cr_reg) + (ROW_W + 1)'(1) < (ROW_W + 1)'(frows_reg));
            nr_c = cr_reg + ROW_W'(1);
        end
        if (ofs.dc == OFS_MINUS)
        begin
            inb  = inb && (cc_reg != '0);
            nc_c = cc_reg - COL_W'(1);
        end
        else if (ofs.dc == OFS_PLUS)
        begin
            inb  = inb && ((COL_W + 1)'(cc_reg) + (COL_W + 1)'(1) < (COL_W + 1)'(fcols_reg));
            nc_c = cc_reg + COL_W'(1);
        end
    end

    always_comb
    begin
        joins = 1'b1;
        delta = '0;
        for (int k = 0; k < 3; k++)
        begin
            delta = (pc_reg[k] > sums_reg[k]) ? pc_reg[k] - sums_reg[k]
                                               : sums_reg[k] - pc_reg[k];
            if (delta > lim_reg)
            begin
                joins = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        load_ptr_next = load_ptr_reg;
        read_ptr_next = read_ptr_reg;
        ready_next    = ready_reg;
        fn_next       = fn_reg;
        frows_next    = frows_reg;
        fcols_next    = fcols_reg;
        idx_next      = idx_reg;
        sr_next       = sr_reg;
        sc_next       = sc_reg;
        rc_next       = rc_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        dir_next      = dir_reg;
        size_next     = size_reg;
        sums_next     = sums_reg;
        cr_next       = cr_reg;
        cc_next       = cc_reg;
        nr_next       = nr_reg;
        nc_next       = nc_reg;
        nidx_next     = nidx_reg;
        pc_next       = pc_reg;
        lim_next      = lim_reg;
        npix_next     = npix_reg;
        lab_next      = lab_reg;
        ov_next       = 1'b0;
        olast_next    = olast_reg;
        omean_next    = omean_reg;
        olab_next     = olab_reg;

        lab_we     = 1'b0;
        lab_addr   = read_ptr_reg;
        lab_wdata  = rc_reg;
        pix_we     = 1'b0;
        pix_addr   = load_ptr_reg;
        pix_wdata  = {ch2, ch1, ch0};
        q_we       = 1'b0;
        q_addr     = head_reg;
        q_wdata    = {nr_reg, nc_reg};
        mean_we    = 1'b0;
        mean_addr  = ADDR_W'(lab_rdata);
        mean_wdata = {div_quot[2], div_quot[1], div_quot[0]};
        div_start  = 1'b0;
        adv_scan   = 1'b0;
        adv_dir    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !kind)
                begin
                    pix_we = 1'b1;
                    if (load_ptr_reg + ADDR_W'(1) >= frame_n)
                    begin
                        load_ptr_next = '0;
                        fn_next       = frame_n;
                        frows_next    = sat_r;
                        fcols_next    = sat_c;
                        idx_next      = '0;
                        state_next    = ST_CLR;
                    end
                    else
                    begin
                        load_ptr_next = load_ptr_reg + ADDR_W'(1);
                    end
                end
                else if (accept && kind)
                begin
                    if (ready_reg)
                    begin
                        olast_next = (read_ptr_reg + ADDR_W'(1) >= fn_reg);
                        read_ptr_next = olast_next ? '0 : read_ptr_reg + ADDR_W'(1);
                        state_next = ST_RLAB;
                    end
                    else
                    begin
                        ov_next    = 1'b1;
                        olast_next = 1'b0;
                        omean_next = '0;
                        olab_next  = '0;
                    end
                end
            end
            ST_RLAB:
            begin
                lab_next   = lab_rdata;
                state_next = ST_RMEAN;
            end
            ST_RMEAN:
            begin
                ov_next    = 1'b1;
                omean_next = mean_rdata;
                olab_next  = lab_reg;
                state_next = ST_IDLE;
            end
            ST_CLR:
            begin
                lab_we    = 1'b1;
                lab_addr  = idx_reg;
                lab_wdata = '0;
                if (idx_reg == fn_reg - ADDR_W'(1))
                begin
                    idx_next   = '0;
                    sr_next    = '0;
                    sc_next    = '0;
                    rc_next    = '0;
                    state_next = ST_SRD;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            ST_SRD:
            begin
                lab_addr   = idx_reg;
                pix_addr   = idx_reg;
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (lab_rdata == '0)
                begin
                    rc_next   = rc_reg + LABEL_W'(1);
                    lab_we    = 1'b1;
                    lab_addr  = idx_reg;
                    lab_wdata = rc_next;
                    q_we      = 1'b1;
                    q_addr    = '0;
                    q_wdata   = {sr_reg, sc_reg};
                    for (int k = 0; k < 3; k++)
                    begin
                        sums_next[k] = SUM_W'(pix_rdata[k*CH_W +: CH_W]);
                    end
                    size_next  = ADDR_W'(1);
                    head_next  = '0;
                    tail_next  = ADDR_W'(1);
                    state_next = ST_GQRD;
                end
                else
                begin
                    adv_scan = 1'b1;
                end
            end
            ST_GQRD:
            begin
                if (head_reg == tail_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_GQWT;
                end
            end
            ST_GQWT:
            begin
                cr_next    = q_rdata[QENT_W-1 -: ROW_W];
                cc_next    = q_rdata[COL_W-1:0];
                dir_next   = '0;
                state_next = ST_NADR;
            end
            ST_NADR:
            begin
                if (inb)
                begin
                    nr_next    = nr_c;
                    nc_next    = nc_c;
                    nidx_next  = ADDR_W'(ADDR_W'(nr_c) * ADDR_W'(fcols_reg)) + ADDR_W'(nc_c);
                    state_next = ST_NRD;
                end
                else
                begin
                    adv_dir = 1'b1;
                end
            end
            ST_NRD:
            begin
                lab_addr   = nidx_reg;
                pix_addr   = nidx_reg;
                state_next = ST_NDAT;
            end
            ST_NDAT:
            begin
                if (lab_rdata != '0)
                begin
                    adv_dir = 1'b1;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        pc_next[k] = SUM_W'(SUM_W'(pix_rdata[k*CH_W +: CH_W]) *
                                            SUM_W'(size_reg));
                    end
                    lim_next   = SUM_W'(SUM_W'(thr_reg) * SUM_W'(size_reg));
                    npix_next  = pix_rdata;
                    state_next = ST_NTST;
                end
            end
            ST_NTST:
            begin
                if (joins)
                begin
                    lab_we   = 1'b1;
                    lab_addr = nidx_reg;
                    q_we     = 1'b1;
                    q_addr   = tail_reg;
                    tail_next = tail_reg + ADDR_W'(1);
                    for (int k = 0; k < 3; k++)
                    begin
                        sums_next[k] = sums_reg[k] + SUM_W'(npix_reg[k*CH_W +: CH_W]);
                    end
                    size_next = size_reg + ADDR_W'(1);
                end
                adv_dir = 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mean_we   = 1'b1;
                    mean_addr = ADDR_W'(rc_reg);
                    adv_scan  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv_dir)
        begin
            if (dir_reg == 3'd7)
            begin
                head_next  = head_reg + ADDR_W'(1);
                state_next = ST_GQRD;
            end
            else
            begin
                dir_next   = dir_reg + 3'd1;
                state_next = ST_NADR;
            end
        end

        if (adv_scan)
        begin
            if (idx_reg == fn_reg - ADDR_W'(1))
            begin
                ready_next    = 1'b1;
                read_ptr_next = '0;
                state_next    = ST_IDLE;
            end
            else
            begin
                idx_next = idx_reg + ADDR_W'(1);
                if ((COL_W + 1)'(sc_reg) + (COL_W + 1)'(1) >= (COL_W + 1)'(fcols_reg))
                begin
                    sc_next = '0;
                    sr_next = sr_reg + ROW_W'(1);
                end
                else
                begin
                    sc_next = sc_reg + COL_W'(1);
                end
                state_next = ST_SRD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_ptr_reg <= '0;
            read_ptr_reg <= '0;
            ready_reg    <= 1'b0;
            fn_reg       <= '0;
            frows_reg    <= '0;
            fcols_reg    <= '0;
            idx_reg      <= '0;
            sr_reg       <= '0;
            sc_reg       <= '0;
            rc_reg       <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            dir_reg      <= '0;
            size_reg     <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_ptr_reg <= load_ptr_next;
            read_ptr_reg <= read_ptr_next;
            ready_reg    <= ready_next;
            fn_reg       <= fn_next;
            frows_reg    <= frows_next;
            fcols_reg    <= fcols_next;
            idx_reg      <= idx_next;
            sr_reg       <= sr_next;
            sc_reg       <= sc_next;
            rc_reg       <= rc_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            dir_reg      <= dir_next;
            size_reg     <= size_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sums_reg  <= sums_next;
        cr_reg    <= cr_next;
        cc_reg    <= cc_next;
        nr_reg    <= nr_next;
        nc_reg    <= nc_next;
        nidx_reg  <= nidx_next;
        pc_reg    <= pc_next;
        lim_reg   <= lim_next;
        npix_reg  <= npix_next;
        lab_reg   <= lab_next;
        olast_reg <= olast_next;
        omean_reg <= omean_next;
        olab_reg  <= olab_next;
    end

    rgcq_ram #(.W(PIX_W), .D(MEM_D)) u_pixel_ram (
        .clk   (clk),
        .we    (pix_we),
        .addr  (pix_addr),
        .wdata (pix_wdata),
        .rdata (pix_rdata)
    );

    rgcq_ram #(.W(LABEL_W), .D(MEM_D)) u_label_ram (
        .clk   (clk),
        .we    (lab_we),
        .addr  (lab_addr),
        .wdata (lab_wdata),
        .rdata (lab_rdata)
    );

    rgcq_ram #(.W(QENT_W), .D(MEM_D)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .addr  (q_addr),
        .wdata (q_wdata),
        .rdata (q_rdata)
    );

    rgcq_ram #(.W(PIX_W), .D(MEM_D)) u_mean_ram (
        .clk   (clk),
        .we    (mean_we),
        .addr  (mean_addr),
        .wdata (mean_wdata),
        .rdata (mean_rdata)
    );

    rgcq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sums  (sums_reg),
        .size  (size_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid    = ov_reg;
    assign out_ch0      = omean_reg[CH_W-1:0];
    assign out_ch1      = omean_reg[2*CH_W-1:CH_W];
    assign out_ch2      = omean_reg[3*CH_W-1:2*CH_W];
    assign region_label = olab_reg;
    assign last_pixel   = olast_reg;

    a_region_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NTST) |-> (size_reg != '0))
        else $error("region test with empty region");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= tail_reg))
        else $error("queue head passed tail");

    a_label_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (lab_we && state_reg != ST_CLR) |-> (lab_wdata != '0))
        else $error("zero label written during growth");

    a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($past(state_reg) == ST_RMEAN ||
                       ($past(accept) && $past(kind) && !$past(ready_reg))))
        else $error("result beat without a read");

endmodule
